FILE: src/torq_pkg.sv
// ----------------------------------------------------------------------------
// torq_pkg: shared types and constants
// Widths, action codes, controller states and the command/status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package torq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int ACT_W  = 2;
  localparam int CHAN_W = 5;
  localparam int ECH_W  = 4;
  localparam int TS_W   = 64;
  localparam int KEY_W  = 32;
  localparam int BODY_W = 64;

  localparam int S_DATA_W = 168;
  localparam int M_DATA_W = 168;
  localparam int M_USER_W = 2;

  localparam logic [ACT_W-1:0] ACT_PASS = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INS  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REL  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REL
  } state_e;

  typedef struct packed {
    logic latch;
    logic mark;
    logic insert;
    logic pop;
    logic emit_msg;
    logic emit_close;
    logic close_status;
  } cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             full;
    logic             head_ok;
    logic             out_free;
  } sts_t;

endpackage

FILE: src/torq_ctrl.sv
// ----------------------------------------------------------------------------
// torq_ctrl: sequencing controller
// Takes one input at a time, runs its action on the datapath and issues
// one result per cycle while the output register is free.
// ----------------------------------------------------------------------------
module torq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  input  torq_pkg::sts_t sts_i,
  output torq_pkg::cmd_t cmd_o
);
  import torq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts_i.action == ACT_REL) begin
          state_d = ST_REL;
        end else if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_REL: begin
        if (sts_i.out_free && !sts_i.head_ok) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o  = 1'b1;
        cmd_o.latch = s_tvalid_i;
      end
      ST_EXEC: begin
        if (sts_i.action != ACT_REL && sts_i.out_free) begin
          cmd_o.emit_close   = 1'b1;
          cmd_o.mark         = (sts_i.action == ACT_PASS);
          cmd_o.insert       = (sts_i.action == ACT_INS) && !sts_i.full;
          cmd_o.close_status = (sts_i.action == ACT_INS) && sts_i.full;
        end
      end
      ST_REL: begin
        if (sts_i.out_free) begin
          if (sts_i.head_ok) begin
            cmd_o.emit_msg = 1'b1;
            cmd_o.pop      = 1'b1;
          end else begin
            cmd_o.emit_close = 1'b1;
          end
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

FILE: src/torq_dp.sv
// ----------------------------------------------------------------------------
// torq_dp: queue datapath
// Sorted row of entry cells with parallel compare-and-shift insert, head
// pop, pass marking, the latched input item and the output register.
// ----------------------------------------------------------------------------
module torq_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  torq_pkg::cmd_t                      cmd_i,
  output torq_pkg::sts_t                      sts_o,
  input  logic [torq_pkg::S_DATA_W-1:0]       s_tdata_i,
  input  logic [torq_pkg::ACT_W-1:0]          s_tuser_i,
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  output logic [torq_pkg::M_DATA_W-1:0]       m_tdata_o,
  output logic [torq_pkg::M_USER_W-1:0]       m_tuser_o,
  output logic                                m_tlast_o
);
  import torq_pkg::*;

  // latched input item
  logic [ACT_W-1:0]  act_q;
  logic [CHAN_W-1:0] chan_q;
  logic [TS_W-1:0]   ts_q;
  logic [KEY_W-1:0]  key_q;
  logic [BODY_W-1:0] body_q;

  // entry cells, slot 0 is the head
  logic [TS_W-1:0]   ent_ts_q   [QUEUE_DEPTH];
  logic [KEY_W-1:0]  ent_key_q  [QUEUE_DEPTH];
  logic [BODY_W-1:0] ent_body_q [QUEUE_DEPTH];
  logic [ECH_W-1:0]  ent_ch_q   [QUEUE_DEPTH];
  logic              ent_old_q  [QUEUE_DEPTH];
  logic [CNT_W-1:0]  count_q;

  logic [QUEUE_DEPTH-1:0] lt;
  logic [QUEUE_DEPTH-1:0] shift_in;
  logic [QUEUE_DEPTH-1:0] put;

  // output register
  logic              m_valid_q;
  logic              has_q, st_q, last_q;
  logic [TS_W-1:0]   o_ts_q;
  logic [KEY_W-1:0]  o_key_q;
  logic [BODY_W-1:0] o_body_q;
  logic [ECH_W-1:0]  o_ch_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q  <= s_tuser_i;
      chan_q <= s_tdata_i[CHAN_W-1:0];
      ts_q   <= s_tdata_i[CHAN_W +: TS_W];
      key_q  <= s_tdata_i[CHAN_W+TS_W +: KEY_W];
      body_q <= s_tdata_i[CHAN_W+TS_W+KEY_W +: BODY_W];
    end
  end

  // entries above the new timestamp form a tail; the first of them is the slot, else slot count
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      lt[i] = (CNT_W'(i) < count_q) && (ts_q < ent_ts_q[i]);
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      shift_in[i] = (i > 0) ? lt[(i > 0) ? i - 1 : 0] : 1'b0;
      put[i]      = (lt[i] && !shift_in[i]) ||
                    ((CNT_W'(i) == count_q) && !shift_in[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (cmd_i.insert) begin
        if (put[i]) begin
          ent_ts_q[i]   <= ts_q;
          ent_key_q[i]  <= key_q;
          ent_body_q[i] <= body_q;
          ent_ch_q[i]   <= chan_q[ECH_W-1:0];
          ent_old_q[i]  <= 1'b0;
        end else if (shift_in[i]) begin
          ent_ts_q[i]   <= ent_ts_q[(i > 0) ? i - 1 : 0];
          ent_key_q[i]  <= ent_key_q[(i > 0) ? i - 1 : 0];
          ent_body_q[i] <= ent_body_q[(i > 0) ? i - 1 : 0];
          ent_ch_q[i]   <= ent_ch_q[(i > 0) ? i - 1 : 0];
          ent_old_q[i]  <= ent_old_q[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd_i.pop) begin
        if (i < QUEUE_DEPTH - 1) begin
          ent_ts_q[i]   <= ent_ts_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
          ent_key_q[i]  <= ent_key_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
          ent_body_q[i] <= ent_body_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
          ent_ch_q[i]   <= ent_ch_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
          ent_old_q[i]  <= ent_old_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
        end
      end else if (cmd_i.mark) begin
        ent_old_q[i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.insert) begin
      count_q <= count_q + CNT_W'(1);
    end else if (cmd_i.pop) begin
      count_q <= count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.emit_msg || cmd_i.emit_close) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_msg) begin
      has_q    <= 1'b1;
      st_q     <= 1'b0;
      last_q   <= 1'b0;
      o_ts_q   <= ent_ts_q[0];
      o_key_q  <= ent_key_q[0];
      o_body_q <= ent_body_q[0];
      o_ch_q   <= ent_ch_q[0];
    end else if (cmd_i.emit_close) begin
      has_q    <= 1'b0;
      st_q     <= cmd_i.close_status;
      last_q   <= 1'b1;
      o_ts_q   <= '0;
      o_key_q  <= '0;
      o_body_q <= '0;
      o_ch_q   <= '0;
    end
  end

  assign sts_o.action   = act_q;
  assign sts_o.full     = (count_q == CNT_W'(QUEUE_DEPTH));
  assign sts_o.head_ok  = (count_q != '0) && ent_old_q[0] &&
                          ({1'b0, ent_ch_q[0]} <= chan_q);
  assign sts_o.out_free = !m_valid_q || m_tready_i;

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {4'd0, o_ch_q, o_body_q, o_key_q, o_ts_q};
  assign m_tuser_o  = {st_q, has_q};
  assign m_tlast_o  = last_q;

endmodule

FILE: src/timestamp_ordered_release_queue.sv
// ----------------------------------------------------------------------------
// timestamp_ordered_release_queue: timestamp-ordered merge queue
// Holds up to 32 messages sorted by timestamp and releases them per pass.
//
//  channel | dir | tdata (low bit up)                 | tuser          | tlast
//  s_*     | in  | channel, msg_ts, msg_key, msg_body | action         | -
//  m_*     | out | out_ts, out_key, out_body, out_ch  | has_msg,status | last
//
// Start pass, insert and unused actions first take the transfer; once
// the output register is free, they update the queue and load that register.
// Release takes the transfer, decodes it, then emits the released
// entries in turn as the output register frees and ends with the
// closing item; the head pop shifts the whole entry row at once.
// Reset is asynchronous and empties the queue at once. A stalled output
// holds the controller in place; a new input is taken while the last
// result still waits.
// ----------------------------------------------------------------------------
module timestamp_ordered_release_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  // channel[4:0], msg_ts[68:5], msg_key[100:69], msg_body[164:101], zero fill
  input  logic [torq_pkg::S_DATA_W-1:0] s_tdata_i,
  // action[1:0]
  input  logic [torq_pkg::ACT_W-1:0]    s_tuser_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  // out_ts[63:0], out_key[95:64], out_body[159:96], out_channel[163:160], zero fill
  output logic [torq_pkg::M_DATA_W-1:0] m_tdata_o,
  // has_msg[0], status[1]
  output logic [torq_pkg::M_USER_W-1:0] m_tuser_o,
  output logic                          m_tlast_o
);
  import torq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  torq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  torq_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

endmodule
